FILE: hdl/ccac_pkg.sv
package ccac_pkg;

    // Field and register widths.
    localparam int BYTE_W     = 8;
    localparam int LEFT_W     = 13;
    localparam int FILL_W     = 6;
    localparam int LEN_W      = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 24;
    localparam int M_TUSER_W  = 2;

    // Saturation point of the bytes-left count.
    localparam int STREAM_LEN_MAX = 4096;

    // Register map, as word index taken from paddr[2].
    localparam logic REG_MAX_CHUNK_SIZE = 1'b0;

    // Reset value of the chunk limit.
    localparam logic [FILL_W-1:0] MAX_CHUNK_RESET = 6'd31;

    // Caption command lead byte codes.
    localparam logic [BYTE_W-1:0] CMD_EXT1     = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_P16      = 8'h18;
    localparam logic [BYTE_W-1:0] C0_LAST      = 8'h1F;
    localparam logic [BYTE_W-1:0] G0_LAST      = 8'h7F;
    localparam logic [BYTE_W-1:0] G1_FIRST     = 8'hA0;
    localparam logic [BYTE_W-1:0] CW_LAST      = 8'h87;
    localparam logic [BYTE_W-1:0] DLY_LAST     = 8'h8D;
    localparam logic [BYTE_W-1:0] RST_LAST     = 8'h8F;
    localparam logic [BYTE_W-1:0] CMD_SPA      = 8'h90;
    localparam logic [BYTE_W-1:0] CMD_SPC      = 8'h91;
    localparam logic [BYTE_W-1:0] CMD_SPL      = 8'h92;
    localparam logic [BYTE_W-1:0] CMD_SWA      = 8'h97;

    // Command length in bytes, lead byte included.
    function automatic logic [LEN_W-1:0] command_length(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] len;
        if (b >= 8'h20 && b <= G0_LAST) begin
            len = 3'd1;
        end else if (b >= G1_FIRST) begin
            len = 3'd1;
        end else if (b == CMD_EXT1) begin
            len = 3'd2;
        end else if (b == CMD_P16) begin
            len = 3'd3;
        end else if (b <= C0_LAST) begin
            len = 3'd1;
        end else if (b <= CW_LAST) begin
            len = 3'd1;
        end else if (b <= DLY_LAST) begin
            len = 3'd2;
        end else if (b <= RST_LAST) begin
            len = 3'd1;
        end else if (b == CMD_SPA) begin
            len = 3'd3;
        end else if (b == CMD_SPC) begin
            len = 3'd4;
        end else if (b == CMD_SPL) begin
            len = 3'd3;
        end else if (b == CMD_SWA) begin
            len = 3'd5;
        end else begin
            len = 3'd7;
        end
        return len;
    endfunction

endpackage

FILE: hdl/caption_command_aligned_chunker_unit.sv
// Command-aligned chunker for a caption service byte stream.
//
// Input stream (s_*): one transfer per byte; s_tdata carries the stream byte
// and the count of bytes left in the stream, this byte included. A count of
// one (or zero) marks the final byte.
// Output stream (m_*): one transfer per input byte, carrying the byte with a
// chunk-start and a command-start flag in m_tuser; m_tlast marks stream end.
// A chunk is cut before any command lead byte whose command would not fit in the
// open chunk, so commands no longer than the chunk limit are never split.
//
// m_tvalid rises in the cycle after the input transfer. Throughput is one byte
// per cycle while the receiver keeps up: the command decode, the clamp and the
// fill compare sit in one stage ahead of the output register, and a new byte
// is taken in the same cycle that the held result is taken downstream.
// Reset clears the argument and fill counters, empties the output register
// and sets the chunk limit to 31. The limit lives at APB address 0x0.
// When the receiver stalls, the output register holds its transfer and
// s_tready drops until that transfer is taken.
module caption_command_aligned_chunker_unit
    import ccac_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] stream_byte, [20:8] bytes_left
    // Output stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [BYTE_W-1:0]     m_tdata,   // [7:0] out_byte
    output logic [M_TUSER_W-1:0]  m_tuser,   // [0] chunk_start, [1] command_start
    output logic                  m_tlast    // stream_end
);

    logic [FILL_W-1:0] max_chunk_size_reg;
    logic [LEN_W-1:0]  args_pending_reg, args_pending_next;
    logic [FILL_W-1:0] chunk_fill_reg, chunk_fill_next;
    logic              m_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              chunk_start_reg, chunk_start_next;
    logic              command_start_reg, command_start_next;
    logic              stream_end_reg, stream_end_next;

    logic              cfg_write;
    logic              s_accept;
    logic [BYTE_W-1:0] stream_byte;
    logic [LEFT_W-1:0] bytes_left;
    logic [FILL_W-1:0] limit;
    logic [LEN_W-1:0]  len_raw;
    logic [LEN_W-1:0]  len_lim;
    logic [LEN_W-1:0]  len_clamped;
    logic [FILL_W:0]   fill_sum;
    logic              cut;
    logic [FILL_W-1:0] fill_base;

    // Configuration register access.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chunk_size_reg <= MAX_CHUNK_RESET;
        end else if (cfg_write && paddr[2] == REG_MAX_CHUNK_SIZE) begin
            max_chunk_size_reg <= pwdata[FILL_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_CHUNK_SIZE) begin
            prdata = {{(CFG_DATA_W-FILL_W){1'b0}}, max_chunk_size_reg};
        end
    end

    // Input handshake: take a byte whenever the output register is free or draining.
    assign s_tready    = !m_valid_reg || m_tready;
    assign s_accept    = s_tvalid && s_tready;
    assign stream_byte = s_tdata[BYTE_W-1:0];
    assign bytes_left  = s_tdata[BYTE_W +: LEFT_W];

    // Command decode, clamping and chunk cut decision.
    always_comb begin
        limit           = (max_chunk_size_reg == '0) ? FILL_W'(1) : max_chunk_size_reg;
        stream_end_next = (bytes_left <= LEFT_W'(1));
        len_raw         = command_length(stream_byte);

        // Clamp to the chunk limit, then to the bytes left in the stream.
        len_lim = len_raw;
        if ({{(FILL_W-LEN_W){1'b0}}, len_raw} > limit) begin
            len_lim = limit[LEN_W-1:0];
        end
        len_clamped = len_lim;
        if (stream_end_next) begin
            len_clamped = LEN_W'(1);
        end else if (bytes_left < {{(LEFT_W-LEN_W){1'b0}}, len_lim}) begin
            len_clamped = bytes_left[LEN_W-1:0];
        end

        fill_sum = {1'b0, chunk_fill_reg} + {{(FILL_W+1-LEN_W){1'b0}}, len_clamped};
        command_start_next = (args_pending_reg == '0);
        cut = command_start_next && (fill_sum > {1'b0, limit});

        chunk_start_next = (chunk_fill_reg == '0) || cut;
        fill_base        = cut ? '0 : chunk_fill_reg;

        if (command_start_next) begin
            args_pending_next = len_clamped - LEN_W'(1);
        end else begin
            args_pending_next = args_pending_reg - LEN_W'(1);
        end
        chunk_fill_next = fill_base + FILL_W'(1);

        // The final byte closes everything, pending arguments included.
        if (stream_end_next) begin
            args_pending_next = '0;
            chunk_fill_next   = '0;
        end
    end

    // Chunker state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            args_pending_reg <= '0;
            chunk_fill_reg   <= '0;
        end else if (s_accept) begin
            args_pending_reg <= args_pending_next;
            chunk_fill_reg   <= chunk_fill_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_byte_reg      <= stream_byte;
            chunk_start_reg   <= chunk_start_next;
            command_start_reg <= command_start_next;
            stream_end_reg    <= stream_end_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {command_start_reg, chunk_start_reg};
    assign m_tlast  = stream_end_reg;

    // Checks.

    // The final byte leaves both counters at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && stream_end_next) |=> (args_pending_reg == '0 && chunk_fill_reg == '0))
        else $error("counters not cleared after final byte");

    // Pending arguments always belong to an open chunk.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (args_pending_reg != '0) |-> (chunk_fill_reg != '0))
        else $error("arguments pending with no open chunk");

    // A byte taken while no chunk is open always opens one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && chunk_fill_reg == '0) |=> (m_tvalid && m_tuser[0]))
        else $error("chunk start missing on first byte of a chunk");

    // A cut only happens at a command lead byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && chunk_fill_reg != '0 && args_pending_reg != '0) |=> !m_tuser[0])
        else $error("chunk cut inside a command");

endmodule
